// File: sv/srpm_pkg.sv
// Shared ring pointer manager: common types, codes and constants.
package srpm_pkg;

    localparam int PTR_W           = 32;
    localparam int ID_W            = 4;
    localparam int OP_W            = 2;
    localparam int SUBSCRIBERS_DEF = 16;

    localparam logic [PTR_W-1:0] PTR_MASK_RST = 32'd4095;

    // request opcodes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_SYNC  = 2'd2;

    // configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_RING_IS_TX = 1'b0;
    localparam t_cfg_idx CFG_PTR_MASK   = 1'b1;

    // datapath actions
    typedef logic [3:0] t_act;
    localparam t_act ACT_NONE     = 4'd0;
    localparam t_act ACT_NULL     = 4'd1;
    localparam t_act ACT_START    = 4'd2;
    localparam t_act ACT_STOP_FIN = 4'd3;
    localparam t_act ACT_STOP_A   = 4'd4;
    localparam t_act ACT_RSVD     = 4'd5;
    localparam t_act ACT_RX_WR    = 4'd6;
    localparam t_act ACT_RX_FIN   = 4'd7;
    localparam t_act ACT_TX_A     = 4'd8;
    localparam t_act ACT_TX_B     = 4'd9;
    localparam t_act ACT_TX_C     = 4'd10;
    localparam t_act ACT_DET_KEY  = 4'd11;
    localparam t_act ACT_DET_FIN  = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ID_W-1:0]  sub_id;
        logic [PTR_W-1:0] sub_sw_pointer;
        logic [PTR_W-1:0] sub_hw_pointer;
        logic [PTR_W-1:0] hw_pointer;
    } t_req;

    typedef struct packed {
        logic [PTR_W-1:0] out_hw_pointer;
        logic [PTR_W-1:0] out_sw_pointer;
        logic             swptr_written;
        logic [PTR_W-1:0] swptr_value;
        logic             lock_held;
        logic             first_start;
        logic             last_stop;
    } t_rsp;

    typedef struct packed {
        logic load;
        t_act act;
        logic walk_clr;
        logic walk_run;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            id_ok;
        logic            ring_tx;
        logic            id_active;
        logic            walk_last;
        logic            out_free;
    } t_sts;

endpackage

// File: sv/srpm_stream_if.sv
// Valid/ready stream channel carrying one payload beat.
interface srpm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/srpm_ram.sv
// Generic single write port RAM with registered read.
module srpm_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/srpm_ctrl.sv
// Sequencer: decodes the request and steps the datapath through it.
module srpm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  srpm_pkg::t_sts i_sts,
    output srpm_pkg::t_cmd o_cmd
);
    import srpm_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DET_KEY  = 3'd2;
    localparam logic [2:0] S_WALK     = 3'd3;
    localparam logic [2:0] S_WALK_END = 3'd4;
    localparam logic [2:0] S_FIN      = 3'd5;
    localparam logic [2:0] S_TX_B     = 3'd6;
    localparam logic [2:0] S_TX_C     = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.id_ok) begin
                    if (i_sts.out_free) begin
                        o_cmd.act = ACT_NULL;
                        n_state   = S_IDLE;
                    end
                end else begin
                    unique case (i_sts.op)
                        OP_START: begin
                            if (i_sts.out_free) begin
                                o_cmd.act = ACT_START;
                                n_state   = S_IDLE;
                            end
                        end
                        OP_STOP: begin
                            if (i_sts.id_active) begin
                                o_cmd.act = ACT_STOP_A;
                                n_state   = S_DET_KEY;
                            end else if (i_sts.out_free) begin
                                o_cmd.act = ACT_STOP_FIN;
                                n_state   = S_IDLE;
                            end
                        end
                        OP_SYNC: begin
                            if (i_sts.ring_tx) begin
                                o_cmd.act = ACT_TX_A;
                                n_state   = S_TX_B;
                            end else begin
                                o_cmd.act      = ACT_RX_WR;
                                o_cmd.walk_clr = 1'b1;
                                n_state        = S_WALK;
                            end
                        end
                        default: begin
                            if (i_sts.out_free) begin
                                o_cmd.act = ACT_RSVD;
                                n_state   = S_IDLE;
                            end
                        end
                    endcase
                end
            end
            S_DET_KEY: begin
                o_cmd.act      = ACT_DET_KEY;
                o_cmd.walk_clr = 1'b1;
                n_state        = S_WALK;
            end
            S_WALK: begin
                o_cmd.walk_run = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_WALK_END;
                end
            end
            S_WALK_END: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.act = (i_sts.op == OP_STOP) ? ACT_DET_FIN : ACT_RX_FIN;
                    n_state   = S_IDLE;
                end
            end
            S_TX_B: begin
                o_cmd.act = ACT_TX_B;
                n_state   = S_TX_C;
            end
            S_TX_C: begin
                if (i_sts.out_free) begin
                    o_cmd.act = ACT_TX_C;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

// File: sv/srpm_dp.sv
// Datapath: channel pointers, lock, attach state, reader memories and result register.
module srpm_dp #(
    parameter int SUBSCRIBERS = srpm_pkg::SUBSCRIBERS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  srpm_pkg::t_cmd           i_cmd,
    output srpm_pkg::t_sts           o_sts,
    input  srpm_pkg::t_req           i_req_data,
    input  logic                     i_rsp_ready,
    output logic                     o_rsp_valid,
    output srpm_pkg::t_rsp           o_rsp_data,
    input  logic                     i_cfg_wr_en,
    input  srpm_pkg::t_cfg_idx       i_cfg_idx,
    input  logic [srpm_pkg::PTR_W-1:0] i_cfg_wdata
);
    import srpm_pkg::*;

    localparam int IDX_W = $clog2(SUBSCRIBERS);
    localparam int CNT_W = $clog2(SUBSCRIBERS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SUBSCRIBERS - 1);

    // control state
    logic                   r_ring_tx,  n_ring_tx;
    logic [PTR_W-1:0]       r_ptr_mask, n_ptr_mask;
    logic [PTR_W-1:0]       r_chw,      n_chw;
    logic [PTR_W-1:0]       r_csw,      n_csw;
    logic [SUBSCRIBERS-1:0] r_active,   n_active;
    logic                   r_lock_vld, n_lock_vld;
    logic [ID_W-1:0]        r_lock_own, n_lock_own;
    logic [CNT_W-1:0]       r_count,    n_count;
    logic                   r_pend,     n_pend;
    logic                   r_out_vld,  n_out_vld;

    // payload
    t_req                   r_req,       n_req;
    logic [IDX_W-1:0]       r_walk,      n_walk;
    logic [IDX_W-1:0]       r_pend_idx,  n_pend_idx;
    logic [PTR_W-1:0]       r_best,      n_best;
    logic [PTR_W-1:0]       r_pick,      n_pick;
    logic [IDX_W-1:0]       r_best_rank, n_best_rank;
    logic [IDX_W-1:0]       r_key,       n_key;
    logic                   r_last,      n_last;
    logic                   r_wr,        n_wr;
    logic [PTR_W-1:0]       r_wval,      n_wval;
    logic [PTR_W-1:0]       r_len,       n_len;
    t_rsp                   r_out,       n_out;

    // memories
    logic                   ptr_we;
    logic [IDX_W-1:0]       ptr_waddr;
    logic [PTR_W-1:0]       ptr_wdata;
    logic [PTR_W-1:0]       ptr_rdata;
    logic                   rank_we;
    logic [IDX_W-1:0]       rank_waddr;
    logic [IDX_W-1:0]       rank_wdata;
    logic [IDX_W-1:0]       rank_raddr;
    logic [IDX_W-1:0]       rank_rdata;

    logic [IDX_W-1:0]       idx;
    logic                   id_ok;
    logic                   owns;
    logic                   tx_free;
    logic [PTR_W-1:0]       chw_start;
    logic [PTR_W-1:0]       tx_csw;
    logic [PTR_W-1:0]       room;
    logic [PTR_W-1:0]       lag;
    logic                   better;
    logic                   pend_act;

    srpm_ram #(.WIDTH(PTR_W), .DEPTH(SUBSCRIBERS)) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (ptr_we),
        .i_waddr (ptr_waddr),
        .i_wdata (ptr_wdata),
        .i_raddr (r_walk),
        .o_rdata (ptr_rdata)
    );

    // attach rank: 0 for the earliest attached reader
    srpm_ram #(.WIDTH(IDX_W), .DEPTH(SUBSCRIBERS)) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rank_we),
        .i_waddr (rank_waddr),
        .i_wdata (rank_wdata),
        .i_raddr (rank_raddr),
        .o_rdata (rank_rdata)
    );

    assign idx       = IDX_W'(r_req.sub_id);
    assign id_ok     = 32'(r_req.sub_id) < 32'(SUBSCRIBERS);
    assign owns      = r_lock_vld && (r_lock_own == r_req.sub_id);
    assign tx_free   = owns || !r_lock_vld;
    assign chw_start = (!r_active[idx] && r_count == '0) ? r_req.hw_pointer : r_chw;
    assign tx_csw    = (owns && r_req.sub_hw_pointer != r_csw) ? r_req.sub_hw_pointer : r_csw;
    assign room      = (r_chw + ~r_csw) & r_ptr_mask;
    assign lag       = (r_chw - ptr_rdata) & r_ptr_mask;
    assign better    = (lag > r_best) ||
                       (lag == r_best && lag != '0 && rank_rdata < r_best_rank);
    assign pend_act  = r_pend && r_active[r_pend_idx];
    assign rank_raddr = i_cmd.walk_run ? r_walk : idx;

    assign o_sts.op        = r_req.op;
    assign o_sts.id_ok     = id_ok;
    assign o_sts.ring_tx   = r_ring_tx;
    assign o_sts.id_active = id_ok && r_active[idx];
    assign o_sts.walk_last = (r_walk == LAST_IDX);
    assign o_sts.out_free  = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_rsp_data  = r_out;

    always_comb begin
        n_ring_tx   = r_ring_tx;
        n_ptr_mask  = r_ptr_mask;
        n_chw       = r_chw;
        n_csw       = r_csw;
        n_active    = r_active;
        n_lock_vld  = r_lock_vld;
        n_lock_own  = r_lock_own;
        n_count     = r_count;
        n_pend      = i_cmd.walk_run;
        n_out_vld   = r_out_vld && !i_rsp_ready;
        n_req       = i_cmd.load ? i_req_data : r_req;
        n_pend_idx  = r_walk;
        n_best      = r_best;
        n_pick      = r_pick;
        n_best_rank = r_best_rank;
        n_key       = r_key;
        n_last      = r_last;
        n_wr        = r_wr;
        n_wval      = r_wval;
        n_len       = r_len;
        n_out       = r_out;

        ptr_we      = 1'b0;
        ptr_waddr   = idx;
        ptr_wdata   = chw_start;
        rank_we     = 1'b0;
        rank_waddr  = idx;
        rank_wdata  = IDX_W'(r_count);

        if (i_cmd.walk_clr) begin
            n_walk = '0;
        end else if (i_cmd.walk_run) begin
            n_walk = r_walk + IDX_W'(1);
        end else begin
            n_walk = r_walk;
        end

        if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_RING_IS_TX: n_ring_tx  = i_cfg_wdata[0];
                CFG_PTR_MASK:   n_ptr_mask = i_cfg_wdata;
                default: ;
            endcase
        end

        // entry that the walk read in the previous cycle
        if (pend_act) begin
            if (r_req.op == OP_SYNC) begin
                if (better) begin
                    n_best      = lag;
                    n_pick      = ptr_rdata;
                    n_best_rank = rank_rdata;
                end
            end else if (rank_rdata > r_key) begin
                rank_we    = 1'b1;
                rank_waddr = r_pend_idx;
                rank_wdata = rank_rdata - IDX_W'(1);
            end
        end

        case (i_cmd.act)
            ACT_NULL: begin
                n_out     = '0;
                n_out_vld = 1'b1;
            end
            ACT_START: begin
                if (!r_active[idx]) begin
                    if (r_count == '0) begin
                        n_chw = r_req.hw_pointer;
                        n_csw = r_req.hw_pointer;
                    end
                    n_count       = r_count + CNT_W'(1);
                    n_active[idx] = 1'b1;
                    rank_we       = 1'b1;
                    rank_waddr    = idx;
                    rank_wdata    = IDX_W'(r_count);
                end
                ptr_we                = 1'b1;
                ptr_waddr             = idx;
                ptr_wdata             = chw_start;
                n_out                 = '0;
                n_out.out_hw_pointer  = chw_start;
                n_out.out_sw_pointer  = chw_start;
                n_out.lock_held       = owns;
                n_out.first_start     = !r_active[idx] && r_count == '0;
                n_out_vld             = 1'b1;
            end
            ACT_STOP_FIN: begin
                if (owns) begin
                    n_lock_vld = 1'b0;
                end
                n_out     = '0;
                n_out_vld = 1'b1;
            end
            ACT_STOP_A: begin
                if (owns) begin
                    n_lock_vld = 1'b0;
                end
                n_count       = r_count - CNT_W'(1);
                n_active[idx] = 1'b0;
                n_last        = (r_count == CNT_W'(1));
            end
            ACT_DET_KEY: begin
                n_key = rank_rdata;
            end
            ACT_DET_FIN: begin
                n_out           = '0;
                n_out.last_stop = r_last;
                n_out_vld       = 1'b1;
            end
            ACT_RSVD: begin
                n_out                = '0;
                n_out.out_hw_pointer = r_chw;
                n_out.out_sw_pointer = r_csw;
                n_out.lock_held      = owns;
                n_out_vld            = 1'b1;
            end
            ACT_RX_WR: begin
                ptr_we      = 1'b1;
                ptr_waddr   = idx;
                ptr_wdata   = r_req.sub_sw_pointer;
                n_best      = '0;
                n_pick      = r_req.sub_sw_pointer;
                n_best_rank = '0;
            end
            ACT_RX_FIN: begin
                n_out = '0;
                if (r_pick != r_csw) begin
                    n_csw               = r_pick;
                    n_out.swptr_written = 1'b1;
                    n_out.swptr_value   = r_pick;
                end
                n_chw                = r_req.hw_pointer;
                n_out.out_hw_pointer = r_req.hw_pointer;
                n_out.lock_held      = owns;
                n_out_vld            = 1'b1;
            end
            ACT_TX_A: begin
                n_wr   = 1'b0;
                n_wval = '0;
                if (tx_free) begin
                    if (tx_csw != r_csw) begin
                        n_wr   = 1'b1;
                        n_wval = tx_csw;
                    end
                    n_csw = tx_csw;
                    n_chw = r_req.hw_pointer;
                    n_len = (r_req.sub_sw_pointer - r_req.sub_hw_pointer) & r_ptr_mask;
                end
            end
            ACT_TX_B: begin
                if (room < r_len) begin
                    n_len = room;
                end
            end
            ACT_TX_C: begin
                n_out                = '0;
                n_out.out_hw_pointer = r_csw;
                n_out.out_sw_pointer = r_csw;
                if (tx_free) begin
                    if (owns && r_len == '0) begin
                        n_lock_vld = 1'b0;
                    end
                    if (!owns && r_len != '0) begin
                        n_lock_vld = 1'b1;
                        n_lock_own = r_req.sub_id;
                    end
                    n_out.out_sw_pointer = (r_csw + r_len) & r_ptr_mask;
                    n_out.swptr_written  = r_wr;
                    n_out.swptr_value    = r_wval;
                    n_out.lock_held      = (r_len != '0);
                end
                n_out_vld = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_tx  <= 1'b0;
            r_ptr_mask <= PTR_MASK_RST;
            r_chw      <= '0;
            r_csw      <= '0;
            r_active   <= '0;
            r_lock_vld <= 1'b0;
            r_lock_own <= '0;
            r_count    <= '0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ring_tx  <= n_ring_tx;
            r_ptr_mask <= n_ptr_mask;
            r_chw      <= n_chw;
            r_csw      <= n_csw;
            r_active   <= n_active;
            r_lock_vld <= n_lock_vld;
            r_lock_own <= n_lock_own;
            r_count    <= n_count;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_walk      <= n_walk;
        r_pend_idx  <= n_pend_idx;
        r_best      <= n_best;
        r_pick      <= n_pick;
        r_best_rank <= n_best_rank;
        r_key       <= n_key;
        r_last      <= n_last;
        r_wr        <= n_wr;
        r_wval      <= n_wval;
        r_len       <= n_len;
        r_out       <= n_out;
    end
endmodule

// File: sv/shared_ring_pointer_manager.sv
// Shared ring pointer manager: top level joining sequencer and datapath.
//
//  channel   dir  payload                       beat taken when
//  i_req     in   srpm_pkg::t_req               valid & ready
//  o_rsp     out  srpm_pkg::t_rsp               valid & ready
//  i_cfg_*   in   index + 32-bit data           i_cfg_wr_en
//
// RX sync and stop of an attached subscriber walk over the reader memories,
// one entry a cycle; start, reserved, idle-stop and TX sync beats do not walk.
// One request is worked at a time; the next is taken once its result is in
// the output register. A stalled o_rsp holds the final step of the next beat.
// Reset is synchronous; reader memories need no clearing pass.
module shared_ring_pointer_manager #(
    parameter int SUBSCRIBERS = srpm_pkg::SUBSCRIBERS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    srpm_stream_if.sink                i_req,
    srpm_stream_if.source              o_rsp,
    input  logic                       i_cfg_wr_en,
    input  srpm_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [srpm_pkg::PTR_W-1:0] i_cfg_wdata
);
    import srpm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic req_ready;
    logic rsp_valid;
    t_rsp rsp_data;

    srpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    srpm_dp #(.SUBSCRIBERS(SUBSCRIBERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_data  (i_req.data),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (rsp_valid),
        .o_rsp_data  (rsp_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;
    assign o_rsp.data  = rsp_data;
endmodule
